[sv/mfd_pkg.sv]
package mfd_pkg;

  localparam logic [7:0] MARK_START0 = 8'h40;  // '@'
  localparam logic [7:0] MARK_START1 = 8'h23;  // '#'
  localparam logic [7:0] MARK_END0   = 8'h24;  // '$'
  localparam logic [7:0] MARK_END1   = 8'h25;  // '%'

  localparam logic [1:0] KIND_TOPIC   = 2'd0;
  localparam logic [1:0] KIND_MESSAGE = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [7:0] TOPIC_RESET = 8'd32;
  localparam int         QDEPTH      = 4;

  // work handed from the parser to the output side
  typedef enum logic [1:0] {
    OP_RESTART,  // clear body position, no result
    OP_BODY1,    // one body byte
    OP_BODY2,    // held '$' and then the byte
    OP_END       // frame end item
  } op_kind_t;

  typedef struct packed {
    op_kind_t   op;
    logic [7:0] data;
  } req_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } result_t;

endpackage

[sv/marker_frame_deframer.sv]
// An accepted byte is written to the request queue, its results to the result buffer.
// Throughput: one byte per cycle while the queue is not full; a byte that releases a
//   held '$' and itself makes two results, which the output side writes one at a time.
// The request queue (QUEUE_DEPTH entries) and a two-entry result buffer absorb stalls.
// Reset: synchronous, active low; parser hunts, topic length 32, queues empty.
module marker_frame_deframer #(
  parameter int QUEUE_DEPTH = mfd_pkg::QDEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_restart,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_last,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);
  import mfd_pkg::*;

  logic accept;
  logic q_wr, q_rd, q_empty;
  req_t q_wdata, q_rdata;

  assign accept = push && !full;

  mfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_byte    (in_byte),
    .in_restart (in_restart),
    .q_wr       (q_wr),
    .q_req      (q_wdata)
  );

  mfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (full)
  );

  mfd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_vld    (!q_empty),
    .q_req    (q_rdata),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .out_kind (out_kind),
    .out_last (out_last)
  );

endmodule

[sv/mfd_front.sv]
module mfd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          in_restart,
  output logic          q_wr,
  output mfd_pkg::req_t q_req
);
  import mfd_pkg::*;

  localparam logic [1:0] PH_HUNT      = 2'd0;
  localparam logic [1:0] PH_HUNT_AT   = 2'd1;
  localparam logic [1:0] PH_BODY      = 2'd2;
  localparam logic [1:0] PH_BODY_HELD = 2'd3;

  logic [1:0] phase_r, phase_nxt;

  always_comb begin
    phase_nxt  = phase_r;
    q_wr       = 1'b0;
    q_req.op   = OP_BODY1;
    q_req.data = in_byte;
    if (accept) begin
      if (in_restart) begin
        phase_nxt = PH_HUNT;
        q_wr      = 1'b1;
        q_req.op  = OP_RESTART;
      end else begin
        unique case (phase_r)
          PH_HUNT: begin
            if (in_byte == MARK_START0) phase_nxt = PH_HUNT_AT;
          end
          PH_HUNT_AT: begin
            // body position is already zero whenever hunting
            if (in_byte == MARK_START1) phase_nxt = PH_BODY;
            else if (in_byte != MARK_START0) phase_nxt = PH_HUNT;
          end
          PH_BODY: begin
            if (in_byte == MARK_END0) begin
              phase_nxt = PH_BODY_HELD;
            end else begin
              q_wr = 1'b1;
            end
          end
          PH_BODY_HELD: begin
            q_wr = 1'b1;
            if (in_byte == MARK_END1) begin
              q_req.op  = OP_END;
              phase_nxt = PH_HUNT;
            end else if (in_byte == MARK_END0) begin
              q_req.op = OP_BODY1;  // old '$' out, new one stays held
            end else begin
              q_req.op  = OP_BODY2;
              phase_nxt = PH_BODY;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

[sv/mfd_queue.sv]
module mfd_queue #(
  parameter int DEPTH = mfd_pkg::QDEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  mfd_pkg::req_t wdata,
  input  logic          rd,
  output mfd_pkg::req_t rdata,
  output logic          empty,
  output logic          full
);
  import mfd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  req_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr) wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (rd) rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (wr && !rd) cnt_nxt = cnt_r + 1'b1;
    else if (rd && !wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[sv/mfd_back.sv]
module mfd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data,
  input  logic          q_vld,
  input  mfd_pkg::req_t q_req,
  output logic          q_rd,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic [1:0]    out_kind,
  output logic          out_last
);
  import mfd_pkg::*;

  logic [7:0] topic_r;
  logic [7:0] pos_r, pos_nxt, pos_inc;
  logic       half_r, half_nxt;
  logic [1:0] body_kind;

  // two-entry result buffer
  result_t    obuf_r [2];
  logic       orp_r, owp_r;
  logic [1:0] ocnt_r, ocnt_nxt;
  logic       pop_out, space, emit;
  result_t    res;

  assign empty    = (ocnt_r == 2'd0);
  assign out_byte = obuf_r[orp_r].data;
  assign out_kind = obuf_r[orp_r].kind;
  assign out_last = obuf_r[orp_r].last;

  assign pop_out   = pop && !empty;
  assign space     = (ocnt_r != 2'd2) || pop_out;
  assign body_kind = (pos_r < topic_r) ? KIND_TOPIC : KIND_MESSAGE;
  assign pos_inc   = (pos_r == 8'hFF) ? pos_r : pos_r + 8'd1;

  always_comb begin
    emit     = 1'b0;
    q_rd     = 1'b0;
    pos_nxt  = pos_r;
    half_nxt = half_r;
    res      = '{data: q_req.data, kind: body_kind, last: 1'b1};
    if (q_vld) begin
      unique case (q_req.op)
        OP_RESTART: begin
          q_rd     = 1'b1;
          pos_nxt  = '0;
          half_nxt = 1'b0;
        end
        OP_END: begin
          if (space) begin
            emit    = 1'b1;
            q_rd    = 1'b1;
            pos_nxt = '0;
            res     = '{data: 8'd0, kind: KIND_END, last: 1'b1};
          end
        end
        OP_BODY1: begin
          if (space) begin
            emit    = 1'b1;
            q_rd    = 1'b1;
            pos_nxt = pos_inc;
          end
        end
        OP_BODY2: begin
          if (space) begin
            emit    = 1'b1;
            pos_nxt = pos_inc;
            if (!half_r) begin
              res      = '{data: MARK_END0, kind: body_kind, last: 1'b0};
              half_nxt = 1'b1;
            end else begin
              q_rd     = 1'b1;
              half_nxt = 1'b0;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (emit && !pop_out) ocnt_nxt = ocnt_r + 2'd1;
    else if (pop_out && !emit) ocnt_nxt = ocnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (emit) obuf_r[owp_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      topic_r <= TOPIC_RESET;
      pos_r   <= '0;
      half_r  <= 1'b0;
      orp_r   <= 1'b0;
      owp_r   <= 1'b0;
      ocnt_r  <= '0;
    end else begin
      if (cfg_we) topic_r <= cfg_data;
      pos_r  <= pos_nxt;
      half_r <= half_nxt;
      if (pop_out) orp_r <= ~orp_r;
      if (emit) owp_r <= ~owp_r;
      ocnt_r <= ocnt_nxt;
    end
  end

endmodule

[sv/mfd_checker.sv]
module mfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic [1:0] out_kind,
  input logic       out_last
);
  import mfd_pkg::*;

  // frame end carries no byte and always closes its request
  a_end_form: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_END) |-> (out_byte == 8'd0 && out_last))
    else $error("frame end item malformed");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_kind <= KIND_END))
    else $error("illegal result kind");

  // the second result of a request follows the first without a gap
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !out_last) |=> !empty)
    else $error("second result of a request missing");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_kind)
                          && $stable(out_last)))
    else $error("waiting result changed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("not empty after reset");

endmodule

bind marker_frame_deframer mfd_checker u_mfd_checker (.*);

[tb/marker_frame_deframer_tb.sv]
module marker_frame_deframer_tb;
  import mfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 260;

  typedef enum logic [1:0] {
    HUNTING,
    SAW_AT,
    IN_BODY,
    HELD_DOLLAR
  } parse_phase_t;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_RANDOM,
    RX_SPARSE,
    RX_BURSTY
  } rx_mode_t;

  typedef struct {
    logic [7:0] data;
    logic       restart;
  } stream_byte_t;

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       push       = 1'b0;
  logic       full;
  logic [7:0] in_byte    = '0;
  logic       in_restart = 1'b0;
  logic       empty;
  logic       pop        = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_last;
  logic       cfg_we     = 1'b0;
  logic [7:0] cfg_data   = '0;

  stream_byte_t stream_q[$];
  result_t      due_results[$];
  stream_byte_t next_byte;

  // shadow of the deframer
  parse_phase_t parse_phase = HUNTING;
  logic [7:0]   body_count  = '0;
  logic [7:0]   topic_cfg   = TOPIC_RESET;

  int       mismatches  = 0;
  int       idle_cycles = 0;
  int       burst_left  = 0;
  int       gap_left    = 0;
  int       rx_left     = 0;
  logic [4:0] rx_tick   = '0;
  rx_mode_t rx_mode     = RX_STEADY;

  marker_frame_deframer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .in_restart(in_restart),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .out_last  (out_last),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic result_t body_result(input logic [7:0] b);
    result_t r;
    r.data = b;
    r.kind = (body_count < topic_cfg) ? KIND_TOPIC : KIND_MESSAGE;
    r.last = 1'b0;
    if (body_count != 8'hFF) body_count = body_count + 8'd1;
    return r;
  endfunction

  task automatic deframe_byte(input logic [7:0] b, input logic restart);
    result_t res[2];
    int n;
    int i;
    n = 0;
    if (restart) begin
      parse_phase = HUNTING;
      body_count = '0;
      return;
    end
    case (parse_phase)
      HUNTING: begin
        if (b == MARK_START0) parse_phase = SAW_AT;
      end
      SAW_AT: begin
        if (b == MARK_START1) begin
          parse_phase = IN_BODY;
          body_count = '0;
        end else if (b != MARK_START0) begin
          parse_phase = HUNTING;
        end
      end
      IN_BODY: begin
        if (b == MARK_END0) begin
          parse_phase = HELD_DOLLAR;
        end else begin
          res[0] = body_result(b);
          n = 1;
        end
      end
      default: begin
        if (b == MARK_END1) begin
          res[0] = '{data: 8'h00, kind: KIND_END, last: 1'b0};
          n = 1;
          parse_phase = HUNTING;
          body_count = '0;
        end else if (b == MARK_END0) begin
          // release the held '$', keep the new one
          res[0] = body_result(MARK_END0);
          n = 1;
        end else begin
          res[0] = body_result(MARK_END0);
          res[1] = body_result(b);
          n = 2;
          parse_phase = IN_BODY;
        end
      end
    endcase
    for (i = 0; i < n; i++) begin
      res[i].last = (i == n - 1);
      due_results.push_back(res[i]);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: byte %h kind %0d last %0d", out_byte, out_kind, out_last);
    end else begin
      want = due_results.pop_front();
      if (out_byte !== want.data || out_kind !== want.kind || out_last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected byte %h kind %0d last %0d, got byte %h kind %0d last %0d",
                   want.data, want.kind, want.last, out_byte, out_kind, out_last);
      end
    end
  endtask

  // driver: bursts of requests separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      in_byte <= '0;
      in_restart <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (push && !full) deframe_byte(in_byte, in_restart);
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          push <= 1'b0;
        end else if (stream_q.size() != 0) begin
          next_byte = stream_q.pop_front();
          push <= 1'b1;
          in_byte <= next_byte.data;
          in_restart <= next_byte.restart;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each popped result, stalls on a changing pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      rx_left <= 0;
      rx_tick <= '0;
      rx_mode <= RX_STEADY;
    end else begin
      if (pop && !empty) check_result();
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(20, 120);
      end else begin
        rx_left <= rx_left - 1;
      end
      rx_tick <= rx_tick + 5'd1;
      case (rx_mode)
        RX_STEADY: pop <= 1'b1;
        RX_RANDOM: pop <= 1'($urandom_range(0, 1));
        RX_SPARSE: pop <= (rx_tick[1:0] == 2'b11);
        default:   pop <= (rx_tick > 5'd24);  // long stalls
      endcase
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic add_byte(input logic [7:0] b, input logic restart = 1'b0);
    stream_byte_t s;
    s.data = b;
    s.restart = restart;
    stream_q.push_back(s);
  endtask

  function automatic logic [7:0] body_byte();
    case ($urandom_range(0, 9))
      0: return MARK_END0;
      1: return ($urandom_range(0, 1) != 0) ? MARK_START0 : MARK_START1;
      2: return MARK_END1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_frame();
    int noise;
    int body_len;
    int i;
    noise = $urandom_range(0, 3);
    for (i = 0; i < noise; i++)
      add_byte(($urandom_range(0, 3) == 0) ? MARK_START0 : 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 15) == 0) begin
      // possible false start: '@' followed by a random byte, which may also be '#'
      add_byte(MARK_START0);
      add_byte(8'($urandom_range(0, 255)));
    end
    add_byte(MARK_START0);
    add_byte(MARK_START1);
    body_len = ($urandom_range(0, 24) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 40);
    for (i = 0; i < body_len; i++) add_byte(body_byte());
    case ($urandom_range(0, 19))
      0: add_byte(8'($urandom_range(0, 255)), 1'b1);  // reconnect mid-frame
      1: ;                                            // unterminated frame
      default: begin
        add_byte(MARK_END0);
        add_byte(MARK_END1);
      end
    endcase
  endtask

  task automatic write_topic(input logic [7:0] len);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    topic_cfg = len;
  endtask

  // wait until every request is in and every result is out,
  // then let restarts still in the request queue retire
  task automatic drain();
    @(negedge clk);
    while (stream_q.size() != 0 || push || due_results.size() != 0) @(negedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    logic [7:0] lengths[5];
    int p;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    write_topic(8'd2);
    add_byte(8'hFF);
    add_byte(MARK_START0);
    add_byte(MARK_START0);  // second '@' still starts the mark
    add_byte(MARK_START1);
    add_byte(8'h00);        // topic
    add_byte(8'h61);        // topic
    add_byte(MARK_END0);
    add_byte(MARK_END0);    // held '$' released, new one held
    add_byte(8'h62);        // releases '$' plus this byte
    add_byte(MARK_START0);  // start mark inside the body is plain data
    add_byte(MARK_START1);
    add_byte(8'hFF);
    add_byte(MARK_END0);
    add_byte(MARK_END1);
    add_byte(MARK_START0);  // empty frame
    add_byte(MARK_START1);
    add_byte(MARK_END0);
    add_byte(MARK_END1);
    add_byte(MARK_START0);
    add_byte(MARK_START1);
    add_byte(8'h78);
    add_byte(MARK_END0);
    add_byte(8'hA5, 1'b1);  // restart drops the held '$'
    add_byte(MARK_START0);
    add_byte(8'h5A, 1'b1);  // restart drops the held '@'
    add_byte(MARK_START1);
    drain();

    lengths = '{8'd1, 8'd255, 8'($urandom_range(2, 254)), 8'd32, 8'd7};
    for (p = 0; p < 5; p++) begin
      write_topic(lengths[p]);
      while (stream_q.size() < PHASE_ITEMS) add_frame();
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
